### hdl/cpm_pkg.sv
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared types, widths and helpers for the third-order 2-D polynomial mapper.
// ----------------------------------------------------------------------------
package cpm_pkg;

  localparam int FRAC_BITS   = 23;
  localparam int COORD_W     = 24;
  localparam int MONO_W      = 25;
  localparam int COEF_W      = 32;
  localparam int SLOT_W      = 5;
  localparam int TABLE_DEPTH = 20;
  localparam int MAX_TERMS   = 10;
  localparam int PROD_W      = COEF_W + MONO_W;
  localparam int ACC_W       = PROD_W + 4;
  localparam int OUT_W       = 32;
  localparam int SHR_W       = ACC_W - FRAC_BITS;

  typedef enum logic [0:0] {
    KIND_XFORM = 1'b0,
    KIND_LOAD  = 1'b1
  } kind_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MONO_W-1:0]  mono_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [OUT_W-1:0]   out_t;

  localparam mono_t MONO_ONE = mono_t'(1) <<< FRAC_BITS;
  localparam out_t  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
  localparam out_t  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

  // Word entering the monomial pipe
  typedef struct packed {
    logic                     load;
    coord_t                   u;
    coord_t                   v;
    logic [SLOT_W-1:0]        slot;
    coef_t                    value;
  } cpm_in_t;

  // Word leaving the monomial pipe
  typedef struct packed {
    logic                     vld;
    logic                     load;
    logic [SLOT_W-1:0]        slot;
    coef_t                    value;
    mono_t [MAX_TERMS-1:0]    mono;
  } cpm_mono_t;

  // Q1.23 product, floor to Q1.23, saturate
  function automatic coord_t q_mul(coord_t a, coord_t b);
    logic signed [2*COORD_W-1:0]           p;
    logic signed [2*COORD_W-FRAC_BITS-1:0] r;
    coord_t                                res;
    p = a * b;
    r = p[2*COORD_W-1:FRAC_BITS];
    if (r[2*COORD_W-FRAC_BITS-1:COORD_W-1] == 2'b01) begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (r[2*COORD_W-FRAC_BITS-1:COORD_W-1] == 2'b10) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = r[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

### hdl/cpm_mono.sv
// ----------------------------------------------------------------------------
// cpm_mono
// Two-stage monomial builder: squares and cross term, then the cubic terms.
// ----------------------------------------------------------------------------
module cpm_mono import cpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  cpm_in_t   word_i,
  output cpm_mono_t word_o
);

  logic    a_vld_q;
  cpm_in_t a_word_q;
  coord_t  a_uu_q, a_vv_q, a_uv_q;
  coord_t  a_uu_d, a_vv_d, a_uv_d;

  logic               b_vld_q;
  logic               b_load_q;
  logic [SLOT_W-1:0]  b_slot_q;
  coef_t              b_value_q;
  mono_t [MAX_TERMS-1:0] b_mono_q;
  mono_t [MAX_TERMS-1:0] b_mono_d;

  assign a_uu_d = q_mul(word_i.u, word_i.u);
  assign a_vv_d = q_mul(word_i.v, word_i.v);
  assign a_uv_d = q_mul(word_i.u, word_i.v);

  // Cubic terms reuse the already rounded squares
  always_comb begin
    b_mono_d[0] = MONO_ONE;
    b_mono_d[1] = mono_t'(a_word_q.u);
    b_mono_d[2] = mono_t'(a_word_q.v);
    b_mono_d[3] = mono_t'(a_uu_q);
    b_mono_d[4] = mono_t'(a_vv_q);
    b_mono_d[5] = mono_t'(a_uv_q);
    b_mono_d[6] = mono_t'(q_mul(a_uu_q, a_word_q.u));
    b_mono_d[7] = mono_t'(q_mul(a_vv_q, a_word_q.v));
    b_mono_d[8] = mono_t'(q_mul(a_uu_q, a_word_q.v));
    b_mono_d[9] = mono_t'(q_mul(a_vv_q, a_word_q.u));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_word_q  <= word_i;
    a_uu_q    <= a_uu_d;
    a_vv_q    <= a_vv_d;
    a_uv_q    <= a_uv_d;
    b_load_q  <= a_word_q.load;
    b_slot_q  <= a_word_q.slot;
    b_value_q <= a_word_q.value;
    b_mono_q  <= b_mono_d;
  end

  assign word_o = '{vld:   b_vld_q,
                    load:  b_load_q,
                    slot:  b_slot_q,
                    value: b_value_q,
                    mono:  b_mono_q};

endmodule

### hdl/cpm_dot.sv
// ----------------------------------------------------------------------------
// cpm_dot
// Coefficient table, term products, adder tree and Q16.16 saturation.
// ----------------------------------------------------------------------------
module cpm_dot import cpm_pkg::*; #(
  parameter int TERMS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cpm_mono_t word_i,
  output logic      done_o,
  output out_t      map_first_o,
  output out_t      map_second_o,
  output logic      clipped_o
);

  coef_t coef_q [TABLE_DEPTH];

  logic  p_vld_q;
  prod_t p_q [MAX_TERMS][2];
  prod_t p_d [MAX_TERMS][2];

  logic  s5_vld_q;
  acc_t  s5_q [5][2];

  logic  s6_vld_q;
  acc_t  s6_q [2][2];

  logic  o_vld_q;
  out_t  o_map_q [2];
  logic  o_clip_q;
  out_t  o_map_d [2];
  logic  o_clip_d;

  // Loads write the table at the same stage that transforms read it,
  // so every word sees exactly the loads that came before it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        coef_q[i] <= '0;
      end
    end else if (word_i.vld && word_i.load && (word_i.slot < SLOT_W'(TABLE_DEPTH))) begin
      coef_q[word_i.slot] <= word_i.value;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      for (int a = 0; a < 2; a++) begin
        if (k < TERMS) begin
          p_d[k][a] = prod_t'(coef_q[2*k+a]) * prod_t'(word_i.mono[k]);
        end else begin
          p_d[k][a] = '0;
        end
      end
    end
  end

  // Final sum, floor to Q16.16, saturate
  always_comb begin
    acc_t                    tot;
    logic signed [SHR_W-1:0] shr;
    o_clip_d = 1'b0;
    for (int a = 0; a < 2; a++) begin
      tot = s6_q[0][a] + s6_q[1][a];
      shr = tot[ACC_W-1:FRAC_BITS];
      if (shr[SHR_W-1:OUT_W-1] != {(SHR_W-OUT_W+1){shr[SHR_W-1]}}) begin
        o_map_d[a] = shr[SHR_W-1] ? OUT_MIN : OUT_MAX;
        o_clip_d   = 1'b1;
      end else begin
        o_map_d[a] = shr[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      p_vld_q  <= word_i.vld & ~word_i.load;
      s5_vld_q <= p_vld_q;
      s6_vld_q <= s5_vld_q;
      o_vld_q  <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < MAX_TERMS; k++) begin
        p_q[k][a] <= p_d[k][a];
      end
      for (int j = 0; j < 5; j++) begin
        s5_q[j][a] <= acc_t'(p_q[2*j][a]) + acc_t'(p_q[2*j+1][a]);
      end
      s6_q[0][a] <= s5_q[0][a] + s5_q[1][a] + s5_q[2][a];
      s6_q[1][a] <= s5_q[3][a] + s5_q[4][a];
      o_map_q[a] <= o_map_d[a];
    end
    o_clip_q <= o_clip_d;
  end

  assign done_o       = o_vld_q;
  assign map_first_o  = o_map_q[0];
  assign map_second_o = o_map_q[1];
  assign clipped_o    = o_clip_q;

endmodule

### hdl/cubic_2d_polynomial_mapping.sv
// ----------------------------------------------------------------------------
// cubic_2d_polynomial_mapping
// Third-order 2-D polynomial mapper with a loadable coefficient table.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at each clock edge where start_i is high; busy_o stays
//   low, so a new word can enter every cycle. kind_i selects a transform
//   (coord_u_i, coord_v_i in Q1.23) or a coefficient load (coef_slot_i,
//   coef_value_i in Q16.16; slots 20 and above are dropped).
//   A transform returns map_first_o, map_second_o (Q16.16, saturated) and
//   clipped_o, marked by done_o for one cycle. A load returns nothing.
//   Throughput is one word per cycle. The word passes through the input
//   register, two monomial multiply stages, the coefficient product stage,
//   two adder tree stages and an output stage that adds the last pair and
//   saturates.
//   Loads update the table in program order with respect to transforms.
//   Reset clears all coefficients and drops every word in flight.
//   The result side has no backpressure: each result is valid for one cycle.
// ----------------------------------------------------------------------------
module cubic_2d_polynomial_mapping import cpm_pkg::*; #(
  parameter int TERMS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 kind_i,
  input  logic signed [23:0]   coord_u_i,
  input  logic signed [23:0]   coord_v_i,
  input  logic [4:0]           coef_slot_i,
  input  logic signed [31:0]   coef_value_i,
  output logic                 done_o,
  output logic signed [31:0]   map_first_o,
  output logic signed [31:0]   map_second_o,
  output logic                 clipped_o
);

  logic      acc_in;
  logic      in_vld_q;
  cpm_in_t   in_word_q;
  cpm_mono_t mono_word;

  assign busy_o = 1'b0;
  assign acc_in = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= acc_in;
    end
  end

  always_ff @(posedge clk_i) begin
    in_word_q <= '{load:  (kind_i == KIND_LOAD),
                   u:     coord_u_i,
                   v:     coord_v_i,
                   slot:  coef_slot_i,
                   value: coef_value_i};
  end

  cpm_mono u_mono (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld_q),
    .word_i (in_word_q),
    .word_o (mono_word)
  );

  cpm_dot #(
    .TERMS (TERMS)
  ) u_dot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (mono_word),
    .done_o       (done_o),
    .map_first_o  (map_first_o),
    .map_second_o (map_second_o),
    .clipped_o    (clipped_o)
  );

`ifndef NO_ASSERTIONS
  a_xform_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && kind_i == KIND_XFORM) |-> ##7 done_o)
    else $error("transform word gave no result");

  a_load_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && kind_i == KIND_LOAD) |-> ##7 !done_o)
    else $error("load word gave a result");

  a_idle_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_in |-> ##7 !done_o)
    else $error("result without a word");

  a_clip_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clipped_o) |->
      (map_first_o == OUT_MAX || map_first_o == OUT_MIN ||
       map_second_o == OUT_MAX || map_second_o == OUT_MIN))
    else $error("clip flag without a saturated output");
`endif

endmodule
